FILE: rtl/rnsp_pkg.sv
// shared types, constants and helpers for the radix number string parser
// no dependencies
package rnsp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DIGIT_W = 5;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_BIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 5'd16;

  // digit value of a non-digit character
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
  localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_PREFIX,
    PH_DIGITS,
    PH_FAIL
  } phase_t;

  // one classified character as it travels from front to back
  typedef struct packed {
    logic               is_nul;
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_zero;
    logic               is_b;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
  } token_t;

  function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = DIGIT_W'(c - CH_UP_A + 8'd10);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d = DIGIT_W'(c - CH_LO_A + 8'd10);
    end
    return d;
  endfunction

endpackage

FILE: rtl/rnsp_front.sv
// front part: takes characters and classifies them into tokens for the queue
// depends on rnsp_pkg
module rnsp_front import rnsp_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              q_full,
  output logic              push,
  output token_t            tok
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    tok.is_nul   = (char_code == CH_NUL);
    tok.is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    tok.is_plus  = (char_code == CH_PLUS);
    tok.is_minus = (char_code == CH_MINUS);
    tok.is_zero  = (char_code == CH_ZERO);
    tok.is_b     = (char_code == CH_UP_B) || (char_code == CH_LO_B);
    tok.is_x     = (char_code == CH_UP_X) || (char_code == CH_LO_X);
    tok.digit    = digit_value(char_code);
  end

endmodule

FILE: rtl/rnsp_queue.sv
// two-entry token queue between the front and back parts
// depends on rnsp_pkg
module rnsp_queue import rnsp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_tok,
  input  logic   pop,
  output token_t head_tok,
  output logic   empty,
  output logic   full
);

  token_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign head_tok = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/rnsp_back.sv
// back part: parse state machine, accumulator and the result register
// depends on rnsp_pkg
module rnsp_back import rnsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [RADIX_W-1:0]        radix,
  input  token_t                    tok,
  input  logic                      q_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] value,
  output logic                      is_number
);

  phase_t               phase, phase_next;
  logic [VALUE_W-1:0]   acc, acc_next;
  logic                 negative, negative_next;
  logic                 saw_digit, saw_digit_next;
  logic                 trailing_junk, trailing_junk_next;
  logic                 out_valid_next;
  logic                 take_digit;
  logic                 digit_ok;
  logic [VALUE_W-1:0]   mac;
  logic [VALUE_W-1:0]   result_value;
  logic                 result_ok;

  // a terminator needs the result register free, anything else goes through
  assign pop = !q_empty && (!tok.is_nul || !out_valid || !out_stall);

  assign digit_ok = tok.digit < radix;
  assign mac      = acc * VALUE_W'(radix) + VALUE_W'(tok.digit);

  always_comb begin
    result_value = '0;
    result_ok    = 1'b0;
    if (phase == PH_DIGITS) begin
      result_value = negative ? (VALUE_W'(0) - acc) : acc;
      result_ok    = saw_digit && !trailing_junk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SPACE;
      acc           <= '0;
      negative      <= 1'b0;
      saw_digit     <= 1'b0;
      trailing_junk <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      acc           <= acc_next;
      negative      <= negative_next;
      saw_digit     <= saw_digit_next;
      trailing_junk <= trailing_junk_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.is_nul) begin
      value     <= result_value;
      is_number <= result_ok;
    end
  end

  always_comb begin
    phase_next         = phase;
    acc_next           = acc;
    negative_next      = negative;
    saw_digit_next     = saw_digit;
    trailing_junk_next = trailing_junk;
    take_digit         = 1'b0;

    if (pop && tok.is_nul) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end

    if (pop) begin
      if (tok.is_nul) begin
        phase_next         = PH_SPACE;
        acc_next           = '0;
        negative_next      = 1'b0;
        saw_digit_next     = 1'b0;
        trailing_junk_next = 1'b0;
      end else begin
        unique case (phase)
          PH_SPACE: begin
            if (!tok.is_space) begin
              if (radix == RADIX_DEC) begin
                phase_next = PH_DIGITS;
                if (tok.is_minus) begin
                  negative_next = 1'b1;
                end else if (!tok.is_plus) begin
                  take_digit = 1'b1;
                end
              end else if (radix == RADIX_BIN || radix == RADIX_OCT || radix == RADIX_HEX) begin
                if (!tok.is_zero) begin
                  phase_next = PH_FAIL;
                end else begin
                  phase_next = (radix == RADIX_OCT) ? PH_DIGITS : PH_PREFIX;
                end
              end else begin
                phase_next = PH_FAIL;
              end
            end
          end
          PH_PREFIX: begin
            if ((radix == RADIX_BIN && tok.is_b) || (radix == RADIX_HEX && tok.is_x)) begin
              phase_next = PH_DIGITS;
            end else begin
              phase_next = PH_FAIL;
            end
          end
          PH_DIGITS: take_digit = 1'b1;
          PH_FAIL:   phase_next = PH_FAIL;
          default:   phase_next = PH_FAIL;
        endcase
      end
    end

    if (take_digit && !trailing_junk) begin
      if (digit_ok) begin
        acc_next       = mac;
        saw_digit_next = 1'b1;
      end else begin
        trailing_junk_next = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/radix_number_string_parser.sv
// top level of the radix number string parser
// depends on rnsp_pkg, rnsp_front, rnsp_queue, rnsp_back
//
// Takes one character per cycle, back to back, unless in_stall is high, and returns
// one result (value and is_number) for each NUL terminator. Accepted characters reach
// the parse logic through a two-entry queue; a result is registered on the output when
// its NUL is popped. Sustained rate is one character per cycle while nothing stalls,
// set by the combinational multiply-and-add step of the back part; a stalled result
// holds only the NUL behind it, while one further character queues up before in_stall
// rises. The radix register is written through cfg_wr_en / cfg_wr_data and resets to
// 10; write it only while the parser is idle, which the block itself does not enforce.
module radix_number_string_parser import rnsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [RADIX_W-1:0]        cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CHAR_W-1:0]         char_code,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] value,
  output logic                      is_number
);

  logic [RADIX_W-1:0] radix;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  token_t             front_tok;
  token_t             head_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  rnsp_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .q_full    (q_full),
    .push      (push),
    .tok       (front_tok)
  );

  rnsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (front_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .empty    (q_empty),
    .full     (q_full)
  );

  rnsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .radix     (radix),
    .tok       (head_tok),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .is_number (is_number)
  );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for radix_number_string_parser: random strings per radix
// depends on rnsp_pkg and the radix_number_string_parser rtl
module testbench;
  import rnsp_pkg::*;

  localparam int PHASE_COUNT      = 12;
  localparam int CHARS_PER_PHASE  = 150;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES    = 4;
  // far above the slowest legal run (all gaps and stalls at their longest)
  localparam int CYCLE_LIMIT      = 400000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [RADIX_W-1:0]        cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [CHAR_W-1:0]         char_code;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [VALUE_W-1:0] value;
  logic                      is_number;

  radix_number_string_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .is_number  (is_number)
  );

  class number_scoreboard;
    typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               ok;
    } number_t;

    number_t            expected_numbers[$];
    logic [RADIX_W-1:0] radix;
    phase_t             parse_phase;
    logic [VALUE_W-1:0] acc;
    logic               neg;
    logic               saw_digit;
    logic               junk;
    int                 mismatches;
    int                 chars_seen;
    int                 strings_seen;
    int                 good_numbers;

    function new();
      radix        = RADIX_RESET;
      mismatches   = 0;
      chars_seen   = 0;
      strings_seen = 0;
      good_numbers = 0;
      clear();
    endfunction

    function void clear();
      parse_phase = PH_SPACE;
      acc         = '0;
      neg         = 1'b0;
      saw_digit   = 1'b0;
      junk        = 1'b0;
    endfunction

    function void set_radix(logic [RADIX_W-1:0] r);
      radix = r;
    endfunction

    // 0..15 for hex digits of either case, 16 for anything else
    function logic [DIGIT_W-1:0] char_digit(logic [CHAR_W-1:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_W'(c - CH_ZERO);
      if (c >= CH_UP_A && c <= CH_UP_F) return DIGIT_W'(c - CH_UP_A) + 5'd10;
      if (c >= CH_LO_A && c <= CH_LO_F) return DIGIT_W'(c - CH_LO_A) + 5'd10;
      return DIGIT_NONE;
    endfunction

    function void take_digit(logic [CHAR_W-1:0] c);
      logic [DIGIT_W-1:0] d;
      if (junk) return;
      d = char_digit(c);
      if (d < radix) begin
        acc       = acc * VALUE_W'(radix) + VALUE_W'(d);
        saw_digit = 1'b1;
      end else begin
        junk = 1'b1;
      end
    endfunction

    function void note_char(logic [CHAR_W-1:0] c);
      number_t n;
      chars_seen++;
      if (c == CH_NUL) begin
        n = '0;
        if (parse_phase == PH_DIGITS) begin
          n.value = neg ? -acc : acc;
          n.ok    = saw_digit && !junk;
        end
        good_numbers += n.ok;
        strings_seen++;
        expected_numbers.push_back(n);
        clear();
        return;
      end
      case (parse_phase)
        PH_SPACE: begin
          if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            if (radix == RADIX_DEC) begin
              parse_phase = PH_DIGITS;
              if (c == CH_MINUS) neg = 1'b1;
              else if (c != CH_PLUS) take_digit(c);
            end else if (radix == RADIX_BIN || radix == RADIX_OCT || radix == RADIX_HEX) begin
              if (c != CH_ZERO) parse_phase = PH_FAIL;
              else parse_phase = (radix == RADIX_OCT) ? PH_DIGITS : PH_PREFIX;
            end else begin
              parse_phase = PH_FAIL;
            end
          end
        end
        PH_PREFIX: begin
          if ((radix == RADIX_BIN && (c == CH_LO_B || c == CH_UP_B)) ||
              (radix == RADIX_HEX && (c == CH_LO_X || c == CH_UP_X)))
            parse_phase = PH_DIGITS;
          else
            parse_phase = PH_FAIL;
        end
        PH_DIGITS: take_digit(c);
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("mismatch: %s", msg);
    endtask

    task check_number(logic signed [VALUE_W-1:0] v, logic ok);
      number_t n;
      if (expected_numbers.size() == 0) begin
        report_mismatch($sformatf("result with no string pending: value=%0d is_number=%0b",
                                  v, ok));
        return;
      end
      n = expected_numbers.pop_front();
      if (v !== n.value)
        report_mismatch($sformatf("value %0d, expected %0d", v, $signed(n.value)));
      if (ok !== n.ok)
        report_mismatch($sformatf("is_number %0b, expected %0b (value %0d)", ok, n.ok, v));
    endtask
  endclass

  number_scoreboard   sb;
  logic [CHAR_W-1:0]  str_buf[$];
  int                 idle_pct;
  int                 stall_pct;
  bit                 quiet;
  bit                 long_hold_req;
  int                 cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.expected_numbers.size());
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stall bursts plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_number(value, is_number);
  end

  function automatic logic [CHAR_W-1:0] digit_char(int unsigned d);
    if (d < 10) return CH_ZERO + CHAR_W'(d);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + CHAR_W'(d - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] space_char();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + CHAR_W'(k);
  endfunction

  function void push_text(string t);
    for (int i = 0; i < t.len(); i++) str_buf.push_back(t[i]);
    str_buf.push_back(CH_NUL);
  endfunction

  // one NUL-terminated string: mostly well-formed for radix r, some corrupted, some noise
  function void build_string(logic [RADIX_W-1:0] r);
    int unsigned mode;
    int unsigned k;
    int unsigned n_digits;
    int unsigned digit_span;
    str_buf.delete();
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      repeat ($urandom_range(0, 6)) str_buf.push_back(CHAR_W'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) str_buf.push_back(space_char());
      if (r == RADIX_BIN || r == RADIX_OCT || r == RADIX_HEX) str_buf.push_back(CH_ZERO);
      if (r == RADIX_BIN) str_buf.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
      if (r == RADIX_HEX) str_buf.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
      if (r == RADIX_DEC) begin
        k = $urandom_range(0, 2);
        if (k == 1) str_buf.push_back(CH_PLUS);
        else if (k == 2) str_buf.push_back(CH_MINUS);
      end
      // mostly short numbers, some long enough to wrap 32 bits, some with no digits
      k = $urandom_range(0, 9);
      n_digits = (k == 0) ? 0 : (k == 1) ? $urandom_range(20, 34) : $urandom_range(1, 8);
      digit_span = (r >= 2 && r <= 16) ? r : 16;
      repeat (n_digits) str_buf.push_back(digit_char($urandom_range(0, digit_span - 1)));
      if (mode < 20 && str_buf.size() > 0) begin
        str_buf[$urandom_range(0, str_buf.size() - 1)] = CHAR_W'($urandom_range(1, 255));
      end else if (mode < 30) begin
        str_buf.push_back(CHAR_W'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 3)) str_buf.push_back(digit_char($urandom_range(0, 9)));
      end
    end
    str_buf.push_back(CH_NUL);
  endfunction

  // called just after a falling edge, returns just after one
  task automatic send_char(logic [CHAR_W-1:0] c);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
    sb.note_char(c);
    @(negedge clk);
  endtask

  task automatic send_buffer();
    foreach (str_buf[i]) send_char(str_buf[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_numbers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_radix(logic [RADIX_W-1:0] r);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_radix(r);
    @(negedge clk);
  endtask

  initial begin
    logic [RADIX_W-1:0] radix_plan[PHASE_COUNT];
    int                 phase_chars;
    bit                 hold_done;
    radix_plan = '{5'd16, 5'd2, 5'd8, 5'd10, 5'd0, 5'd31, 5'd3, 5'd16, 5'd2, 5'd8, 5'd10,
                   5'd16};
    sb            = new();
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    char_code     = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    cycle_count   = 0;
    hold_done     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed strings at the reset radix: empty, all whitespace codes, signs,
    // trailing junk and high character codes
    str_buf.delete();
    str_buf.push_back(CH_NUL);
    str_buf.push_back(CH_SPACE);
    for (int i = 0; i < 5; i++) str_buf.push_back(CH_TAB + CHAR_W'(i));
    str_buf.push_back(CH_NUL);
    push_text("+7");
    push_text("-1");
    push_text("12a");
    str_buf.push_back(8'hff);
    str_buf.push_back(8'h80);
    str_buf.push_back(CH_NUL);
    send_buffer();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_drained();
      write_radix(radix_plan[p]);
      idle_pct  = (p % 3 == 0) ? 10 : (p % 3 == 1) ? 30 : 0;
      stall_pct = (p % 3 == 0) ? 20 : (p % 3 == 1) ? 0 : 10;
      quiet     = (p >= PHASE_COUNT - 2);
      phase_chars = 0;
      while (phase_chars < CHARS_PER_PHASE) begin
        build_string(radix_plan[p]);
        send_buffer();
        phase_chars += str_buf.size();
        // result side holds off while requests keep coming, so the input backs up
        if (p == 1 && !hold_done && phase_chars > 30) begin
          long_hold_req = 1'b1;
          hold_done     = 1'b1;
        end
      end
    end
    wait_drained();

    $display("covered %0d characters in %0d strings (%0d well-formed numbers)",
             sb.chars_seen, sb.strings_seen, sb.good_numbers);
    $display("radix settings 2, 3, 8, 10, 16, 0 and 31; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
